[hw/rtl/srdc_pkg.sv]
// ----------------------------------------------------------------------------
// srdc_pkg: shared definitions for the signed radix to digit string core
// Widths, reset values, character codes, register indexes, the sequencer
// state type and the status group of the shared divider.
// ----------------------------------------------------------------------------
package srdc_pkg;

  localparam int DEF_MAX_RADIX   = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int IN_DATA_W  = 32;
  localparam int CHAR_W     = 8;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int NUM_SYMS   = 16;
  localparam int SYM_REG_W  = 64;
  localparam int SYM_TAB_W  = NUM_SYMS * CHAR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Quotient bits retired by the divider in one cycle.
  localparam int DIV_STEP = 8;

  localparam logic [CHAR_W-1:0] SIGN_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] PLUS_CHAR = 8'h2B;
  localparam logic [CHAR_W-1:0] NUL_CHAR  = 8'h00;

  localparam logic [RADIX_W-1:0]   RADIX_RST   = 5'd10;
  localparam logic [SYM_REG_W-1:0] SYM_LO_RST  = 64'h3736353433323130;
  localparam logic [SYM_REG_W-1:0] SYM_HI_RST  = 64'h0000000000003938;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_HI = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_LOAD,
    S_DIV_WAIT,
    S_SIGN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[hw/rtl/srdc_alpha_chk.sv]
// ----------------------------------------------------------------------------
// srdc_alpha_chk: alphabet validity check
// Flags the symbol table as usable when the radix is at least two and every
// symbol in use is distinct and is neither a zero byte nor a sign character.
// ----------------------------------------------------------------------------
module srdc_alpha_chk import srdc_pkg::*; (
  input  logic [RADIX_W-1:0]   radix,
  input  logic [SYM_TAB_W-1:0] syms,
  output logic                 ok
);

  logic bad;

  always_comb begin
    bad = (radix < RADIX_W'(2));
    for (int i = 0; i < NUM_SYMS; i++) begin
      if (RADIX_W'(i) < radix) begin
        if (syms[i*CHAR_W +: CHAR_W] == NUL_CHAR ||
            syms[i*CHAR_W +: CHAR_W] == PLUS_CHAR ||
            syms[i*CHAR_W +: CHAR_W] == SIGN_CHAR) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < NUM_SYMS; j++) begin
          if (RADIX_W'(j) < radix &&
              syms[i*CHAR_W +: CHAR_W] == syms[j*CHAR_W +: CHAR_W]) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  assign ok = ~bad;

endmodule

[hw/rtl/srdc_div.sv]
// ----------------------------------------------------------------------------
// srdc_div: iterative divider by a small radix
// Restoring division of the magnitude by the radix, DIV_STEP quotient bits
// per cycle. Delivers quotient and remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module srdc_div import srdc_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     divisor,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [DIGIT_W-1:0]     remainder,
  output div_sts_t               sts
);

  localparam int QW    = ((VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int STEPS = QW / DIV_STEP;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [QW-1:0]      quo_r, quo_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               done_r;
  logic [RADIX_W-1:0] trial;

  // Each inner step shifts one dividend bit into the remainder.
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial   = {rem_nxt, quo_nxt[QW-1]};
      quo_nxt = {quo_nxt[QW-2:0], 1'b0};
      if (trial >= divisor) begin
        rem_nxt    = DIGIT_W'(trial - divisor);
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(STEPS);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= QW'(dividend);
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r[VALUE_WIDTH-1:0];
  assign remainder = rem_r;
  assign sts.busy  = (cnt_r != '0);
  assign sts.done  = done_r;

endmodule

[hw/rtl/signed_radix_to_digit_string_core.sv]
// ----------------------------------------------------------------------------
// signed_radix_to_digit_string_core: signed integer to text in a set radix
//
//   channel  dir  handshake          payload
//   in_      in   tvalid / tready    tdata[31:0] value (low VALUE_WIDTH used)
//   out_     out  tvalid / tready    tdata[7:0] symbol, tlast last
//   cfg_     in   we                 index, wdata (radix, symbols low/high)
//
// Each digit takes one pass through the shared divider (S_DIV_LOAD, then
// S_DIV_WAIT until done); then each byte leaves at one per cycle while
// out_tready is high. With an invalid alphabet the item is dropped in
// S_CHECK. Reset is synchronous; registers return to radix 10 and
// symbols "0".."9". A stalled output holds only the sign and digit
// emission; a following item can still be accepted and divided.
// ----------------------------------------------------------------------------
module signed_radix_to_digit_string_core import srdc_pkg::*; #(
  parameter int MAX_RADIX   = DEF_MAX_RADIX,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [CHAR_W-1:0]     out_tdata,  // [7:0] symbol
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int STACK_W = VALUE_WIDTH * DIGIT_W;
  localparam int NDIG_W  = $clog2(VALUE_WIDTH + 1);

  state_t state_r, state_nxt;

  logic [RADIX_W-1:0]     radix_r;
  logic [SYM_REG_W-1:0]   sym_lo_r, sym_hi_r;
  logic [RADIX_W-1:0]     eff_radix;
  logic [SYM_TAB_W-1:0]   sym_tab;
  logic                   alpha_ok;

  logic [VALUE_WIDTH-1:0] value;
  logic [VALUE_WIDTH-1:0] mag_r;
  logic                   neg_r;
  logic [STACK_W-1:0]     stack_r;
  logic [NDIG_W-1:0]      ndig_r;

  logic [VALUE_WIDTH-1:0] div_quo;
  logic [DIGIT_W-1:0]     div_rem;
  div_sts_t               div_sts;

  logic                   out_tvalid_r;
  logic [CHAR_W-1:0]      out_sym_r;
  logic                   out_last_r;
  logic                   out_free;

  logic                   accept;
  logic                   div_start;
  logic                   push;
  logic                   load_sign;
  logic                   load_digit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= RADIX_RST;
      sym_lo_r <= SYM_LO_RST;
      sym_hi_r <= SYM_HI_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIX:  radix_r  <= cfg_wdata[RADIX_W-1:0];
        CFG_SYM_LO: sym_lo_r <= cfg_wdata;
        CFG_SYM_HI: sym_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign eff_radix = (radix_r > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX) : radix_r;
  assign sym_tab   = {sym_hi_r, sym_lo_r};

  srdc_alpha_chk u_alpha_chk (
    .radix (eff_radix),
    .syms  (sym_tab),
    .ok    (alpha_ok)
  );

  srdc_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mag_r),
    .divisor   (eff_radix),
    .quotient  (div_quo),
    .remainder (div_rem),
    .sts       (div_sts)
  );

  assign value    = in_tdata[VALUE_WIDTH-1:0];
  assign out_free = ~out_tvalid_r | out_tready;
  assign accept   = in_tvalid & in_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_tvalid) state_nxt = S_CHECK;
      S_CHECK:    state_nxt = alpha_ok ? S_DIV_LOAD : S_IDLE;
      S_DIV_LOAD: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_sts.done) begin
          if (div_quo != '0) state_nxt = S_DIV_LOAD;
          else               state_nxt = neg_r ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN:     if (out_free) state_nxt = S_EMIT;
      S_EMIT:     if (out_free && ndig_r == NDIG_W'(1)) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready  = 1'b0;
    div_start  = 1'b0;
    push       = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    unique case (state_r)
      S_IDLE:     in_tready  = 1'b1;
      S_CHECK:    ;
      S_DIV_LOAD: div_start  = 1'b1;
      S_DIV_WAIT: push       = div_sts.done;
      S_SIGN:     load_sign  = out_free;
      S_EMIT:     load_digit = out_free;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ndig_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        ndig_r <= '0;
      end else if (push) begin
        ndig_r <= ndig_r + 1'b1;
      end else if (load_digit) begin
        ndig_r <= ndig_r - 1'b1;
      end
    end
  end

  // Magnitude, sign and the digit stack; the last digit pushed is the
  // most significant one and sits in the low nibble.
  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r <= value[VALUE_WIDTH-1];
      mag_r <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
    end else if (push) begin
      mag_r <= div_quo;
    end
    if (push) begin
      stack_r <= {stack_r[STACK_W-DIGIT_W-1:0], div_rem};
    end else if (load_digit) begin
      stack_r <= stack_r >> DIGIT_W;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_sign || load_digit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_sign) begin
      out_sym_r  <= SIGN_CHAR;
      out_last_r <= 1'b0;
    end else if (load_digit) begin
      out_sym_r  <= sym_tab[stack_r[DIGIT_W-1:0]*CHAR_W +: CHAR_W];
      out_last_r <= (ndig_r == NDIG_W'(1));
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    load_digit |-> (ndig_r != '0))
    else $error("digit popped from empty stack");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (ndig_r < NDIG_W'(VALUE_WIDTH)))
    else $error("digit stack overflow");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CHECK))
    else $error("accepted item did not start the alphabet check");

  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (load_sign || load_digit) |-> (!out_tvalid_r || out_tready))
    else $error("output register overwritten");
`endif

endmodule
